// File: src/hmsgr_pkg.sv
// Shared beat types and operation codes for the bucketed key-value table.
package hmsgr_pkg;

   // Operation codes carried in the mode field of a request beat.
   localparam logic [2:0] MODE_SET      = 3'd0;
   localparam logic [2:0] MODE_GET      = 3'd1;
   localparam logic [2:0] MODE_REMOVE   = 3'd2;
   localparam logic [2:0] MODE_CONTAINS = 3'd3;
   localparam logic [2:0] MODE_CLEAR    = 3'd4;

   // Width of keys and values.
   localparam int WORD_W = 64;

   typedef struct packed {
      logic [2:0]        mode;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [WORD_W-1:0] read_value;
      logic              overflow;
   } rsp_type;

endpackage

// File: src/hash_map_set_get_remove.sv
// Bucketed key-value table: one memory row per bucket, read, compared across ways, written back.
// The bucket is the low key bits when BUCKETS is a power of two; otherwise a reciprocal
// modulo unit (fold, reciprocal and reduce steps) sets the bucket before the row read.
// A new request is taken only after the last one has finished; clear sweeps one row per cycle.
// Reset: a clearing pass zeroes every row's valid bits; req_stall stays high until it ends.
// A result beat waiting on rsp_stall does not block acceptance of the next request beat.
module hash_map_set_get_remove #(
   parameter int BUCKETS = 64,
   parameter int WAYS    = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hmsgr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hmsgr_pkg::rsp_type rsp_data
);
   import hmsgr_pkg::*;

   localparam int  IDX_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int  WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam bit  POW2       = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam int  CHUNK_W    = 16;
   localparam int  FOLD_W     = 34;
   localparam int  RECIP_W    = 33;

   // Residues of the chunk weights and the scaled reciprocal of the bucket count.
   localparam logic [CHUNK_W-1:0] RES1       = CHUNK_W'((64'd1 << 16) % 64'(BUCKETS));
   localparam logic [CHUNK_W-1:0] RES2       = CHUNK_W'((64'd1 << 32) % 64'(BUCKETS));
   localparam logic [CHUNK_W-1:0] RES3       = CHUNK_W'((64'd1 << 48) % 64'(BUCKETS));
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'((64'd1 << FOLD_W) / 64'(BUCKETS));
   localparam logic [FOLD_W-1:0]  BUCKET_CNT = FOLD_W'(BUCKETS);

   typedef struct packed {
      logic [WAYS-1:0]              valid;
      logic [WAYS-1:0][WORD_W-1:0]  key;
      logic [WAYS-1:0][WORD_W-1:0]  value;
   } row_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_FOLD,
      S_RECIP,
      S_REDUCE,
      S_READ,
      S_EXEC,
      S_CLEAR
   } state_type;

   state_type         state_ff;
   logic [2:0]        op_ff;
   logic [WORD_W-1:0] key_ff;
   logic [WORD_W-1:0] value_ff;
   logic [IDX_W-1:0]  bucket_ff;
   logic [IDX_W-1:0]  sweep_ff;
   logic [FOLD_W-1:0] fold_ff;
   logic [FOLD_W-1:0] quot_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   row_type           rd_row_ff;

   row_type           mem [BUCKETS];

   logic              req_fire;
   logic              exec_fire;
   logic              sweep_last;
   logic [IDX_W-1:0]  direct_bucket;
   logic [IDX_W-1:0]  rd_addr;
   logic [2*CHUNK_W-1:0]        part1;
   logic [2*CHUNK_W-1:0]        part2;
   logic [2*CHUNK_W-1:0]        part3;
   logic [FOLD_W-1:0]           fold_in;
   logic [FOLD_W+RECIP_W-1:0]   recip_prod;
   logic [FOLD_W-1:0]           quot_in;
   logic [FOLD_W-1:0]           quot_scaled;
   logic [FOLD_W-1:0]           rem_raw;
   logic [IDX_W-1:0]            rem_in;
   logic [WAYS-1:0]   hit;
   logic              any_hit;
   logic              any_free;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  free_way;
   row_type           new_row;
   logic              row_we;
   rsp_type           result;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   row_type           mem_wdata;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign exec_fire  = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign sweep_last = (sweep_ff == IDX_W'(BUCKETS - 1));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Bucket from the low key bits; exact only when the bucket count is a power of two.
   assign direct_bucket = IDX_W'(req_data.key & WORD_W'(BUCKETS - 1));
   assign rd_addr       = (state_ff == S_IDLE) ? direct_bucket : bucket_ff;

   // Fold the key: each 16-bit chunk times the residue of its weight, summed below 2^34.
   assign part1   = key_ff[2*CHUNK_W-1:CHUNK_W] * RES1;
   assign part2   = key_ff[3*CHUNK_W-1:2*CHUNK_W] * RES2;
   assign part3   = key_ff[4*CHUNK_W-1:3*CHUNK_W] * RES3;
   assign fold_in = FOLD_W'(key_ff[CHUNK_W-1:0]) + FOLD_W'(part1) + FOLD_W'(part2) +
                    FOLD_W'(part3);

   // Quotient estimate by the scaled reciprocal; it is low by at most one.
   assign recip_prod = fold_ff * RECIP;
   assign quot_in    = recip_prod[FOLD_W+RECIP_W-1:FOLD_W];

   // Remainder from the estimate, with a single corrective subtract.
   assign quot_scaled = quot_ff * BUCKET_CNT;
   assign rem_raw     = fold_ff - quot_scaled;
   assign rem_in      = IDX_W'((rem_raw >= BUCKET_CNT) ? rem_raw - BUCKET_CNT : rem_raw);

   // Compare the key against every way and find the lowest hit and the lowest free way.
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = rd_row_ff.valid[w] && (rd_row_ff.key[w] == key_ff);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit[w]) begin
            hit_way = WAY_W'(w);
         end
         if (!rd_row_ff.valid[w]) begin
            free_way = WAY_W'(w);
         end
      end
      any_hit  = |hit;
      any_free = !(&rd_row_ff.valid);
   end

   // Modify the bucket row and form the result beat.
   always_comb begin
      new_row = rd_row_ff;
      row_we  = 1'b0;
      result  = '0;
      case (op_ff)
         MODE_SET: begin
            if (any_hit) begin
               new_row.value[hit_way] = value_ff;
               row_we                 = 1'b1;
               result.found           = 1'b1;
            end else if (any_free) begin
               new_row.valid[free_way] = 1'b1;
               new_row.key[free_way]   = key_ff;
               new_row.value[free_way] = value_ff;
               row_we                  = 1'b1;
            end else begin
               result.overflow = 1'b1;
            end
         end
         MODE_GET: begin
            if (any_hit) begin
               result.found      = 1'b1;
               result.read_value = rd_row_ff.value[hit_way];
            end
         end
         MODE_REMOVE: begin
            if (any_hit) begin
               new_row.valid[hit_way] = 1'b0;
               row_we                 = 1'b1;
               result.found           = 1'b1;
            end
         end
         MODE_CONTAINS: begin
            result.found = any_hit;
         end
         default: begin
         end
      endcase
   end

   // Single write port: the clearing sweep or the write-back of a modified row.
   always_comb begin
      if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = exec_fire && row_we;
         mem_waddr = bucket_ff;
         mem_wdata = new_row;
      end
   end

   // Bucket memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= mem[rd_addr];
   end

   // Sequencer, request capture and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  op_ff     <= req_data.mode;
                  key_ff    <= req_data.key;
                  value_ff  <= req_data.new_value;
                  bucket_ff <= direct_bucket;
                  sweep_ff  <= '0;
                  if (req_data.mode == MODE_CLEAR) begin
                     state_ff <= S_CLEAR;
                  end else if (POW2) begin
                     state_ff <= S_EXEC;
                  end else begin
                     state_ff <= S_FOLD;
                  end
               end
            end
            S_FOLD: begin
               fold_ff  <= fold_in;
               state_ff <= S_RECIP;
            end
            S_RECIP: begin
               quot_ff  <= quot_in;
               state_ff <= S_REDUCE;
            end
            S_REDUCE: begin
               bucket_ff <= rem_in;
               state_ff  <= S_READ;
            end
            S_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (exec_fire) begin
                  rsp_data_ff  <= result;
                  state_ff     <= S_IDLE;
               end
            end
            S_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_last) begin
                  state_ff <= S_EXEC;
               end
            end
            default: begin
               state_ff <= S_INIT;
               sweep_ff <= '0;
            end
         endcase
      end
   end

endmodule

// File: verif/hash_map_set_get_remove_test.sv
// Self-checking testbench for the bucketed key-value table, with directed rows and a random run.
module hash_map_set_get_remove_test;
   import hmsgr_pkg::*;

   localparam int NUM_BUCKETS = 64;
   localparam int NUM_WAYS    = 4;
   localparam int NUM_SLOTS   = NUM_BUCKETS * NUM_WAYS;
   localparam int RANDOM_OPS  = 1200;
   localparam int HOT_KEYS    = 16;
   localparam int HOT_BUCKETS = 3;

   // Modes the block must treat as no-ops.
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam rsp_type     NO_HIT   = '0;

   // Five keys that all land in bucket 5.
   localparam logic [63:0] B5_A = 64'h0000_0000_0000_0045;
   localparam logic [63:0] B5_B = 64'h0000_0000_0000_0085;
   localparam logic [63:0] B5_C = 64'h0000_0000_0000_00C5;
   localparam logic [63:0] B5_D = 64'h8000_0000_0000_0005;
   localparam logic [63:0] B5_E = 64'h7FFF_FFFF_FFFF_FFC5;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the table.
   bit          slot_used [NUM_SLOTS];
   logic [63:0] slot_key  [NUM_SLOTS];
   logic [63:0] slot_value[NUM_SLOTS];

   rsp_type      pending_rsp[$];
   plan_row_type plan[$];
   logic [63:0]  hot_key[HOT_KEYS];
   int           errors = 0;
   int           stall_left = 0;
   bit           calm = 1'b0;

   hash_map_set_get_remove #(
      .BUCKETS(NUM_BUCKETS),
      .WAYS   (NUM_WAYS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // Applies one request to the shadow table and returns the result it should give.
   function automatic rsp_type predict_table_op(input req_type beat);
      rsp_type res;
      int      base;
      int      hit;
      int      vacant;
      res    = '0;
      base   = int'(beat.key % 64'(NUM_BUCKETS)) * NUM_WAYS;
      hit    = -1;
      vacant = -1;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (slot_used[base + w] && slot_key[base + w] == beat.key && hit < 0) begin
            hit = w;
         end
         if (!slot_used[base + w] && vacant < 0) begin
            vacant = w;
         end
      end
      case (beat.mode)
         MODE_SET: begin
            if (hit >= 0) begin
               slot_value[base + hit] = beat.new_value;
               res.found = 1'b1;
            end else if (vacant >= 0) begin
               slot_used[base + vacant]  = 1'b1;
               slot_key[base + vacant]   = beat.key;
               slot_value[base + vacant] = beat.new_value;
            end else begin
               res.overflow = 1'b1;
            end
         end
         MODE_GET: begin
            if (hit >= 0) begin
               res.found      = 1'b1;
               res.read_value = slot_value[base + hit];
            end
         end
         MODE_REMOVE: begin
            if (hit >= 0) begin
               slot_used[base + hit] = 1'b0;
               res.found = 1'b1;
            end
         end
         MODE_CONTAINS: begin
            res.found = (hit >= 0);
         end
         MODE_CLEAR: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               slot_used[s] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Random gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) begin
         return 0;
      end else if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [2:0] pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 36) begin
         return MODE_SET;
      end else if (r < 60) begin
         return MODE_GET;
      end else if (r < 74) begin
         return MODE_REMOVE;
      end else if (r < 90) begin
         return MODE_CONTAINS;
      end else if (r < 92) begin
         return MODE_CLEAR;
      end
      return 3'($urandom_range(int'(MODE_UNUSED_LO), int'(MODE_UNUSED_HI)));
   endfunction

   function automatic logic [63:0] random_word();
      return {32'($urandom()), 32'($urandom())};
   endfunction

   // A fresh set of keys crowded into a few buckets, so buckets fill and overflow.
   task automatic refresh_hot_keys();
      logic [5:0] crowded[HOT_BUCKETS];
      for (int b = 0; b < HOT_BUCKETS; b++) begin
         crowded[b] = 6'($urandom_range(0, NUM_BUCKETS - 1));
      end
      for (int k = 0; k < HOT_KEYS; k++) begin
         hot_key[k] = {58'(random_word() >> 6), crowded[k % HOT_BUCKETS]};
      end
   endtask

   task automatic add_row(input logic [2:0] mode, input logic [63:0] key,
                          input logic [63:0] value, input bit typed, input rsp_type want);
      plan_row_type row;
      row.beat  = '{mode: mode, key: key, new_value: value};
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endtask

   // Drives one request beat, waits for it to be taken, then records its expected result.
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = predict_table_op(beat);
      pending_rsp.push_back(typed ? want : predicted);
      if ($urandom_range(0, 79) == 0) begin
         calm = ~calm;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the request side until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Result side: checks each accepted beat and throttles with random stalls.
   always @(posedge clock) begin
      rsp_type want;
      logic    stall_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("found", 64'(want.found), 64'(rsp_data.found));
            check_field("read_value", want.read_value, rsp_data.read_value);
            check_field("overflow", 64'(want.overflow), 64'(rsp_data.overflow));
         end
      end
      stall_next = 1'b0;
      if (stall_left > 0) begin
         stall_left--;
         stall_next = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
                                                    $urandom_range(1, 3);
         stall_left--;
         stall_next = 1'b1;
      end
      rsp_stall <= stall_next;
   end

   // Stimulus: reset, directed rows, then random traffic.
   initial begin
      int worked;
      int waited;
      req_type beat;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty table, extreme keys and values, update in place.
      add_row(MODE_GET, 64'd0, ALL_ONES, 1'b1, NO_HIT);
      add_row(MODE_CONTAINS, ALL_ONES, 64'd0, 1'b1, NO_HIT);
      add_row(MODE_REMOVE, 64'd0, ALL_ONES, 1'b1, NO_HIT);
      add_row(MODE_SET, 64'd0, ALL_ONES, 1'b1, NO_HIT);
      add_row(MODE_GET, 64'd0, 64'd0, 1'b1, '{found: 1'b1, read_value: ALL_ONES,
                                              overflow: 1'b0});
      add_row(MODE_SET, ALL_ONES, 64'd0, 1'b1, NO_HIT);
      add_row(MODE_GET, ALL_ONES, ALL_ONES, 1'b1, '{found: 1'b1, read_value: 64'd0,
                                                    overflow: 1'b0});
      add_row(MODE_SET, 64'd0, 64'h0123_4567_89AB_CDEF, 1'b1,
              '{found: 1'b1, read_value: 64'd0, overflow: 1'b0});
      // Fill one bucket, then overflow it.
      add_row(MODE_SET, B5_A, 64'hA, 1'b1, NO_HIT);
      add_row(MODE_SET, B5_B, 64'hB, 1'b1, NO_HIT);
      add_row(MODE_SET, B5_C, 64'hC, 1'b1, NO_HIT);
      add_row(MODE_SET, B5_D, 64'hD, 1'b1, NO_HIT);
      add_row(MODE_SET, B5_E, 64'hE, 1'b1, '{found: 1'b0, read_value: 64'd0,
                                             overflow: 1'b1});
      add_row(MODE_GET, B5_E, 64'd0, 1'b1, NO_HIT);
      // Removing from the middle of a bucket keeps the rest; the freed way is reused.
      add_row(MODE_REMOVE, B5_B, 64'd0, 1'b1, '{found: 1'b1, read_value: 64'd0,
                                                overflow: 1'b0});
      add_row(MODE_GET, B5_C, 64'd0, 1'b0, NO_HIT);
      add_row(MODE_GET, B5_D, 64'd0, 1'b0, NO_HIT);
      add_row(MODE_SET, B5_E, 64'h5555_AAAA_5555_AAAA, 1'b0, NO_HIT);
      add_row(MODE_CONTAINS, B5_E, 64'd0, 1'b0, NO_HIT);
      // Unused modes leave the table alone.
      add_row(MODE_UNUSED_LO, 64'd0, ALL_ONES, 1'b1, NO_HIT);
      add_row(MODE_UNUSED_MID, B5_A, 64'd0, 1'b1, NO_HIT);
      add_row(MODE_UNUSED_HI, ALL_ONES, ALL_ONES, 1'b1, NO_HIT);
      // Clear empties everything.
      add_row(MODE_CLEAR, ALL_ONES, ALL_ONES, 1'b1, NO_HIT);
      add_row(MODE_GET, 64'd0, 64'd0, 1'b1, NO_HIT);
      add_row(MODE_CONTAINS, B5_A, 64'd0, 1'b1, NO_HIT);

      foreach (plan[i]) begin
         send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
      drain_results();

      // Random traffic over a crowded key pool, with some fully random keys.
      refresh_hot_keys();
      worked = 0;
      while (worked < RANDOM_OPS) begin
         beat.mode      = pick_mode();
         beat.key       = ($urandom_range(0, 9) == 0) ? random_word() :
                                                        hot_key[$urandom_range(0, HOT_KEYS - 1)];
         beat.new_value = random_word();
         send_beat(beat, 1'b0, NO_HIT);
         if (beat.mode <= MODE_CLEAR) begin
            worked++;
            if (worked % 150 == 0) begin
               refresh_hot_keys();
            end
            if (worked % 250 == 0) begin
               drain_results();
            end
         end
      end
      req_valid <= 1'b0;

      // Let the last results arrive, then watch for stray beats.
      waited = 0;
      while (pending_rsp.size() > 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (pending_rsp.size() > 0) begin
         $display("%0t: %0d results never arrived, expected %h actual none", $time,
                  pending_rsp.size(), pending_rsp[0]);
         errors++;
      end
      if (errors == 0) begin
         $display("hash_map_set_get_remove test passed");
      end else begin
         $display("hash_map_set_get_remove test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20000000;
      $display("hash_map_set_get_remove test failed");
      $finish;
   end

endmodule

// File: filelist.f
src/hmsgr_pkg.sv
src/hash_map_set_get_remove.sv
verif/hash_map_set_get_remove_test.sv
